[sv/qpn_pkg.sv]
// Shared widths, payload types and sign table for the normalized quaternion product.
// No dependencies; every other file refers to it by scoped names.
package qpn_pkg;

  localparam int CompWidth = 32;
  localparam int FracBits  = 29;
  localparam int NumComp   = 4;

  // Exact product and norm widths
  localparam int ProdW = 2 * CompWidth;
  localparam int SumW  = ProdW + 2;
  localparam int MagW  = SumW - 1;
  localparam int LoW   = CompWidth;
  localparam int HiW   = MagW - LoW;
  localparam int SqW   = 2 * MagW;
  localparam int NormW = SqW + 2;

  // Quotient r^2 * 4^(F+1) / S, its square root and the rounded result
  localparam int QuoW  = 2 * FracBits + 3;
  localparam int RootW = FracBits + 2;
  localparam int RadW  = 2 * RootW;
  localparam int RemW  = RootW + 3;
  localparam int ResW  = FracBits + 1;
  localparam int OutW  = (ResW + 1 > CompWidth) ? ResW + 1 : CompWidth;

  // Pipeline depths
  localparam int ProdLat = 5;
  localparam int SideLat = QuoW + RootW;
  localparam int TotLat  = ProdLat + SideLat + 1;

  typedef logic signed [CompWidth-1:0] comp_t;
  typedef logic [SqW-1:0]   sq_t;
  typedef logic [NormW-1:0] norm_t;
  typedef logic [QuoW-1:0]  quo_t;
  typedef logic [RootW-1:0] root_t;

  // Per-item sideband that rides beside the lanes
  typedef struct packed {
    logic               degen;
    logic [NumComp-1:0] neg;
  } side_t;

  // Bit j of row i set: term p_j * q_(i^j) is subtracted in component i
  localparam logic [NumComp-1:0] QNeg [NumComp] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

[sv/quaternion_product_normalize.sv]
// Normalized Hamilton product, pipelined from accept to valid_o
// (5 product/norm stages, 61 divider stages, 31 square-root stages, 1 output stage).
// Throughput one item per cycle; busy is always low and results cannot be held off.
// Reset clears every valid bit; payload registers are not reset.
// Depends on qpn_pkg, qpn_product, qpn_divider, qpn_sqrt.
module quaternion_product_normalize (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  qpn_pkg::comp_t p_scalar_i,
  input  qpn_pkg::comp_t p_vec_x_i,
  input  qpn_pkg::comp_t p_vec_y_i,
  input  qpn_pkg::comp_t p_vec_z_i,
  input  qpn_pkg::comp_t q_scalar_i,
  input  qpn_pkg::comp_t q_vec_x_i,
  input  qpn_pkg::comp_t q_vec_y_i,
  input  qpn_pkg::comp_t q_vec_z_i,
  output logic           valid_o,
  output qpn_pkg::comp_t r_scalar_o,
  output qpn_pkg::comp_t r_vec_x_o,
  output qpn_pkg::comp_t r_vec_y_o,
  output qpn_pkg::comp_t r_vec_z_o,
  output logic           degenerate_o
);

  qpn_pkg::comp_t p_in [qpn_pkg::NumComp];
  qpn_pkg::comp_t q_in [qpn_pkg::NumComp];
  qpn_pkg::sq_t   sq   [qpn_pkg::NumComp];
  qpn_pkg::norm_t norm;
  qpn_pkg::side_t side;
  qpn_pkg::side_t side_q [qpn_pkg::SideLat];
  qpn_pkg::quo_t  quo  [qpn_pkg::NumComp];
  qpn_pkg::root_t root [qpn_pkg::NumComp];
  qpn_pkg::comp_t res_d [qpn_pkg::NumComp];
  qpn_pkg::comp_t res_q [qpn_pkg::NumComp];
  logic           prod_vld;
  logic [qpn_pkg::NumComp-1:0] div_vld, sqrt_vld;
  logic           valid_q, degen_q;

  assign busy = 1'b0;

  assign p_in = '{p_scalar_i, p_vec_x_i, p_vec_y_i, p_vec_z_i};
  assign q_in = '{q_scalar_i, q_vec_x_i, q_vec_y_i, q_vec_z_i};

  qpn_product u_product (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start && !busy),
    .p_i    (p_in),
    .q_i    (q_in),
    .vld_o  (prod_vld),
    .sq_o   (sq),
    .norm_o (norm),
    .side_o (side)
  );

  // sideband delay matching divider plus square root
  always_ff @(posedge clk_i) begin
    side_q[0] <= side;
    for (int k = 1; k < qpn_pkg::SideLat; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  for (genvar i = 0; i < qpn_pkg::NumComp; i++) begin : g_lane
    logic [qpn_pkg::RootW:0] rnd;
    logic [qpn_pkg::OutW-1:0] mag_w;
    logic [qpn_pkg::OutW-1:0] sgn_w;

    qpn_divider u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (prod_vld),
      .num_i  (sq[i]),
      .den_i  (norm),
      .vld_o  (div_vld[i]),
      .quo_o  (quo[i])
    );

    qpn_sqrt u_sqrt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (div_vld[i]),
      .rad_i  (quo[i]),
      .vld_o  (sqrt_vld[i]),
      .root_o (root[i])
    );

    // adding one and dropping the low root bit gives the magnitude rounded half up
    assign rnd   = {1'b0, root[i]} + (qpn_pkg::RootW+1)'(1);
    assign mag_w = qpn_pkg::OutW'(rnd[qpn_pkg::ResW:1]);
    assign sgn_w = side_q[qpn_pkg::SideLat-1].neg[i] ? -mag_w : mag_w;
    assign res_d[i] = side_q[qpn_pkg::SideLat-1].degen ? '0
                                                      : sgn_w[qpn_pkg::CompWidth-1:0];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= sqrt_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    degen_q <= side_q[qpn_pkg::SideLat-1].degen;
  end

  assign valid_o      = valid_q;
  assign r_scalar_o   = res_q[0];
  assign r_vec_x_o    = res_q[1];
  assign r_vec_y_o    = res_q[2];
  assign r_vec_z_o    = res_q[3];
  assign degenerate_o = degen_q;

endmodule

[sv/qpn_product.sv]
// Exact Hamilton product, magnitudes, squares and squared norm (five stages).
// Depends on qpn_pkg.
module qpn_product (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  qpn_pkg::comp_t         p_i [qpn_pkg::NumComp],
  input  qpn_pkg::comp_t         q_i [qpn_pkg::NumComp],
  output logic                   vld_o,
  output qpn_pkg::sq_t           sq_o [qpn_pkg::NumComp],
  output qpn_pkg::norm_t         norm_o,
  output qpn_pkg::side_t         side_o
);

  logic signed [qpn_pkg::ProdW-1:0] prod_q [qpn_pkg::NumComp][qpn_pkg::NumComp];
  logic signed [qpn_pkg::SumW-1:0]  sum_d  [qpn_pkg::NumComp];
  logic [qpn_pkg::MagW-1:0]         mag_q  [qpn_pkg::NumComp];
  logic [2*qpn_pkg::HiW-1:0]        hh_q   [qpn_pkg::NumComp];
  logic [qpn_pkg::HiW+qpn_pkg::LoW-1:0] hl_q [qpn_pkg::NumComp];
  logic [2*qpn_pkg::LoW-1:0]        ll_q   [qpn_pkg::NumComp];
  qpn_pkg::sq_t                     sq_d   [qpn_pkg::NumComp];
  qpn_pkg::sq_t                     sq_q   [qpn_pkg::NumComp];
  qpn_pkg::sq_t                     sq_e_q [qpn_pkg::NumComp];
  logic [qpn_pkg::NumComp-1:0]      neg_b_q, neg_c_q, neg_d_q, neg_e_q;
  logic                             degen_d_q, degen_e_q;
  qpn_pkg::norm_t                   norm_d, norm_q;
  logic [4:0]                       vld_q;

  // valid bits, one per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  for (genvar i = 0; i < qpn_pkg::NumComp; i++) begin : g_comp
    // stage A: the sixteen partial products
    for (genvar j = 0; j < qpn_pkg::NumComp; j++) begin : g_term
      localparam int Qi = i ^ j;
      always_ff @(posedge clk_i) begin
        prod_q[i][j] <= qpn_pkg::ProdW'(p_i[j]) * qpn_pkg::ProdW'(q_i[Qi]);
      end
    end

    // stage B: component sum and magnitude
    always_comb begin
      sum_d[i] = '0;
      for (int j = 0; j < qpn_pkg::NumComp; j++) begin
        if (qpn_pkg::QNeg[i][j]) begin
          sum_d[i] = sum_d[i] - qpn_pkg::SumW'(prod_q[i][j]);
        end else begin
          sum_d[i] = sum_d[i] + qpn_pkg::SumW'(prod_q[i][j]);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      neg_b_q[i] <= sum_d[i][qpn_pkg::SumW-1];
      mag_q[i]   <= sum_d[i][qpn_pkg::SumW-1] ? qpn_pkg::MagW'(-sum_d[i])
                                              : qpn_pkg::MagW'(sum_d[i]);
    end

    // stage C: square split into three narrow products
    always_ff @(posedge clk_i) begin
      neg_c_q[i] <= neg_b_q[i];
      hh_q[i] <= (2*qpn_pkg::HiW)'(mag_q[i][qpn_pkg::MagW-1:qpn_pkg::LoW])
               * (2*qpn_pkg::HiW)'(mag_q[i][qpn_pkg::MagW-1:qpn_pkg::LoW]);
      hl_q[i] <= (qpn_pkg::HiW+qpn_pkg::LoW)'(mag_q[i][qpn_pkg::MagW-1:qpn_pkg::LoW])
               * (qpn_pkg::HiW+qpn_pkg::LoW)'(mag_q[i][qpn_pkg::LoW-1:0]);
      ll_q[i] <= (2*qpn_pkg::LoW)'(mag_q[i][qpn_pkg::LoW-1:0])
               * (2*qpn_pkg::LoW)'(mag_q[i][qpn_pkg::LoW-1:0]);
    end

    // stage D: recombine the square
    assign sq_d[i] = (qpn_pkg::SqW'(hh_q[i]) << (2*qpn_pkg::LoW))
                   + (qpn_pkg::SqW'(hl_q[i]) << (qpn_pkg::LoW+1))
                   + qpn_pkg::SqW'(ll_q[i]);

    always_ff @(posedge clk_i) begin
      neg_d_q[i] <= neg_c_q[i];
      sq_q[i]    <= sq_d[i];
      neg_e_q[i] <= neg_d_q[i];
      sq_e_q[i]  <= sq_q[i];
    end

    assign sq_o[i] = sq_e_q[i];
  end

  // stage D: zero product flag
  always_ff @(posedge clk_i) begin
    degen_d_q <= (sq_d[0] == '0) && (sq_d[1] == '0) && (sq_d[2] == '0) && (sq_d[3] == '0);
    degen_e_q <= degen_d_q;
  end

  // stage E: squared norm
  always_comb begin
    norm_d = '0;
    for (int i = 0; i < qpn_pkg::NumComp; i++) begin
      norm_d = norm_d + qpn_pkg::NormW'(sq_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q <= norm_d;
  end

  assign vld_o        = vld_q[4];
  assign norm_o       = norm_q;
  assign side_o.degen = degen_e_q;
  assign side_o.neg   = neg_e_q;

endmodule

[sv/qpn_divider.sv]
// Restoring divider, one quotient bit per stage: floor(num * 4^(F+1) / den).
// Depends on qpn_pkg; requires num <= den.
module qpn_divider (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  qpn_pkg::sq_t   num_i,
  input  qpn_pkg::norm_t den_i,
  output logic           vld_o,
  output qpn_pkg::quo_t  quo_o
);

  qpn_pkg::norm_t rem_q [qpn_pkg::QuoW];
  qpn_pkg::norm_t den_q [qpn_pkg::QuoW];
  qpn_pkg::quo_t  quo_q [qpn_pkg::QuoW];
  logic           vld_q [qpn_pkg::QuoW];

  for (genvar k = 0; k < qpn_pkg::QuoW; k++) begin : g_stage
    logic [qpn_pkg::NormW:0] trial;
    qpn_pkg::norm_t          den_s;
    qpn_pkg::quo_t           quo_s;
    logic                    vld_s;
    logic                    take;

    // first stage sees the numerator itself, later ones the doubled remainder
    if (k == 0) begin : g_first
      assign trial = {1'b0, qpn_pkg::NormW'(num_i)};
      assign den_s = den_i;
      assign quo_s = '0;
      assign vld_s = vld_i;
    end else begin : g_next
      assign trial = {rem_q[k-1], 1'b0};
      assign den_s = den_q[k-1];
      assign quo_s = quo_q[k-1];
      assign vld_s = vld_q[k-1];
    end

    assign take = trial >= {1'b0, den_s};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? qpn_pkg::NormW'(trial - {1'b0, den_s}) : trial[qpn_pkg::NormW-1:0];
      den_q[k] <= den_s;
      quo_q[k] <= quo_s | (take ? (qpn_pkg::QuoW'(1) << (qpn_pkg::QuoW-1-k)) : '0);
    end
  end

  assign vld_o = vld_q[qpn_pkg::QuoW-1];
  assign quo_o = quo_q[qpn_pkg::QuoW-1];

endmodule

[sv/qpn_sqrt.sv]
// Digit-by-digit integer square root, one root bit per stage.
// Depends on qpn_pkg.
module qpn_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  qpn_pkg::quo_t  rad_i,
  output logic           vld_o,
  output qpn_pkg::root_t root_o
);

  logic [qpn_pkg::RadW-1:0] rad_q  [qpn_pkg::RootW];
  logic [qpn_pkg::RemW-1:0] rem_q  [qpn_pkg::RootW];
  qpn_pkg::root_t           root_q [qpn_pkg::RootW];
  logic                     vld_q  [qpn_pkg::RootW];

  for (genvar k = 0; k < qpn_pkg::RootW; k++) begin : g_stage
    logic [qpn_pkg::RadW-1:0] rad_s;
    logic [qpn_pkg::RemW-1:0] rem_s, cur, trial;
    qpn_pkg::root_t           root_s;
    logic                     vld_s;
    logic                     take;

    if (k == 0) begin : g_first
      assign rad_s  = qpn_pkg::RadW'(rad_i);
      assign rem_s  = '0;
      assign root_s = '0;
      assign vld_s  = vld_i;
    end else begin : g_next
      assign rad_s  = rad_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
      assign vld_s  = vld_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign cur   = {rem_s[qpn_pkg::RemW-3:0], rad_s[qpn_pkg::RadW-1-2*k -: 2]};
    assign trial = qpn_pkg::RemW'({root_s, 2'b01});
    assign take  = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rad_s;
      rem_q[k]  <= take ? cur - trial : cur;
      root_q[k] <= {root_s[qpn_pkg::RootW-2:0], take};
    end
  end

  assign vld_o  = vld_q[qpn_pkg::RootW-1];
  assign root_o = root_q[qpn_pkg::RootW-1];

endmodule

[sv/qpn_checker.sv]
// Port-level checks on the normalized quaternion product, bound to the top level.
// Depends on qpn_pkg and quaternion_product_normalize.
module qpn_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input qpn_pkg::comp_t r_scalar_o,
  input qpn_pkg::comp_t r_vec_x_o,
  input qpn_pkg::comp_t r_vec_y_o,
  input qpn_pkg::comp_t r_vec_z_o,
  input logic           valid_o,
  input logic           degenerate_o
);

  localparam qpn_pkg::comp_t Unit = qpn_pkg::CompWidth'(1) << qpn_pkg::FracBits;

  logic all_zero, in_range;

  assign all_zero = (r_scalar_o == '0) && (r_vec_x_o == '0)
                 && (r_vec_y_o == '0) && (r_vec_z_o == '0);
  assign in_range = (r_scalar_o <= Unit) && (r_scalar_o >= -Unit)
                 && (r_vec_x_o <= Unit) && (r_vec_x_o >= -Unit)
                 && (r_vec_y_o <= Unit) && (r_vec_y_o >= -Unit)
                 && (r_vec_z_o <= Unit) && (r_vec_z_o >= -Unit);

  // pipeline never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // zero product gives all-zero components
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> all_zero)
    else $error("degenerate item with nonzero components");

  // a nonzero product gives at least one nonzero component
  a_nondegen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !degenerate_o |-> !all_zero)
    else $error("normalized item is all zero");

  // normalized components never exceed 1.0
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> in_range)
    else $error("component magnitude above one");

endmodule

bind quaternion_product_normalize qpn_checker u_qpn_checker (.*);
